[hdl/ivnp_pkg.sv]
`timescale 1ns / 1ps

package ivnp_pkg;

   // Largest numeral accepted before the range error
   localparam int MAX_NUMERAL = 255;
   // Bits needed to hold any numeral up to the limit
   localparam int NUM_W = $clog2(MAX_NUMERAL + 1);

   localparam int QUAL_W = 6;
   localparam int WHOLE_W = 9;
   localparam int HALF_W = 8;
   localparam int ERR_W = 2;

   localparam int CHAR_W = 8;
   localparam int RSP_FIELDS_W = WHOLE_W + HALF_W + ERR_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DATA_W - RSP_FIELDS_W;

   // Parse position inside one name
   typedef enum logic [1:0] {
      PH_START,
      PH_QUALITY,
      PH_DIGITS,
      PH_TAIL
   } phase_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_NO_DIGITS = 2'd1,
      ERR_RANGE     = 2'd2
   } err_type;

   // Parsed name, handed from the character parser to the step calculator
   typedef struct packed {
      logic                     is_negative;
      logic signed [QUAL_W-1:0] quality;
      logic [NUM_W-1:0]         numeral;
      logic                     too_big;
      logic                     digits_seen;
   } name_info_type;

   // Result item, whole steps in the low bits
   typedef struct packed {
      err_type                   error_code;
      logic signed [HALF_W-1:0]  half_steps;
      logic signed [WHOLE_W-1:0] whole_steps;
   } result_type;

endpackage

[hdl/ivnp_parser.sv]
`timescale 1ns / 1ps

module ivnp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char,
   input  logic                   req_last,
   output logic                   info_valid,
   input  logic                   info_ready,
   output ivnp_pkg::name_info_type info
);
   import ivnp_pkg::*;

   localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHR_SHARP = 8'h23;
   localparam logic [CHAR_W-1:0] CHR_A_UP  = 8'h41;
   localparam logic [CHAR_W-1:0] CHR_A_LO  = 8'h61;
   localparam logic [CHAR_W-1:0] CHR_M_UP  = 8'h4D;
   localparam logic [CHAR_W-1:0] CHR_M_LO  = 8'h6D;
   localparam logic [CHAR_W-1:0] CHR_B_LO  = 8'h62;
   localparam logic [CHAR_W-1:0] CHR_D_UP  = 8'h44;
   localparam logic [CHAR_W-1:0] CHR_D_LO  = 8'h64;
   localparam logic [CHAR_W-1:0] CHR_P_UP  = 8'h50;
   localparam logic [CHAR_W-1:0] CHR_P_LO  = 8'h70;
   localparam logic [CHAR_W-1:0] CHR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHR_9     = 8'h39;

   localparam int ACC_W = NUM_W + 4;
   localparam logic signed [QUAL_W:0] QUAL_MAX = (QUAL_W + 1)'(31);
   localparam logic signed [QUAL_W:0] QUAL_MIN = (QUAL_W + 1)'(-32);

   phase_type                phase_ff, phase_in, work_phase;
   logic                     neg_ff, neg_in, work_neg;
   logic signed [QUAL_W-1:0] qual_ff, qual_in, work_qual;
   logic [NUM_W-1:0]         num_ff, num_in, work_num;
   logic                     big_ff, big_in, work_big;
   logic                     seen_ff, seen_in, work_seen;
   logic                     info_valid_ff, info_valid_in;
   name_info_type            info_ff, info_in;

   logic                     accept;
   logic                     is_qual, is_digit, use_qual, use_digit;
   logic signed [QUAL_W:0]   qual_delta, qual_sum;
   logic signed [QUAL_W-1:0] qual_sat;
   logic [ACC_W-1:0]         num_acc;
   logic                     acc_over;

   assign req_ready  = !info_valid_ff || info_ready;
   assign accept     = req_valid && req_ready;
   assign info_valid = info_valid_ff;
   assign info       = info_ff;

   // Quality letter decode
   always_comb begin
      is_qual    = 1'b1;
      qual_delta = '0;
      case (req_char) inside
         CHR_A_UP, CHR_A_LO, CHR_SHARP: qual_delta = (QUAL_W + 1)'(1);
         CHR_M_LO, CHR_B_LO:            qual_delta = (QUAL_W + 1)'(-1);
         CHR_D_UP, CHR_D_LO: begin
            qual_delta = (qual_ff == '0) ? (QUAL_W + 1)'(-2) : (QUAL_W + 1)'(-1);
         end
         CHR_P_UP, CHR_P_LO, CHR_M_UP:  qual_delta = '0;
         default:                       is_qual = 1'b0;
      endcase
   end

   // Saturating quality update
   assign qual_sum = {qual_ff[QUAL_W-1], qual_ff} + qual_delta;
   always_comb begin
      if (qual_sum > QUAL_MAX) begin
         qual_sat = QUAL_W'(QUAL_MAX);
      end else if (qual_sum < QUAL_MIN) begin
         qual_sat = QUAL_W'(QUAL_MIN);
      end else begin
         qual_sat = qual_sum[QUAL_W-1:0];
      end
   end

   // Numeral accumulate: value times ten plus digit
   assign is_digit = req_char inside {[CHR_0:CHR_9]};
   assign num_acc  = (ACC_W'(num_ff) << 3) + (ACC_W'(num_ff) << 1) + ACC_W'(req_char[3:0]);
   assign acc_over = num_acc > ACC_W'(MAX_NUMERAL);

   // Next state and outputs
   always_comb begin
      work_phase = phase_ff;
      work_neg   = neg_ff;
      work_qual  = qual_ff;
      work_num   = num_ff;
      work_big   = big_ff;
      work_seen  = seen_ff;
      use_qual   = 1'b0;
      use_digit  = 1'b0;

      case (phase_ff)
         PH_START: begin
            if (req_char == CHR_MINUS) begin
               work_neg   = 1'b1;
               work_phase = PH_QUALITY;
            end else if (is_qual) begin
               use_qual   = 1'b1;
               work_phase = PH_QUALITY;
            end else begin
               use_digit = 1'b1;
            end
         end
         PH_QUALITY: begin
            if (is_qual) begin
               use_qual = 1'b1;
            end else begin
               use_digit = 1'b1;
            end
         end
         PH_DIGITS: use_digit = 1'b1;
         default: ;
      endcase

      if (use_qual) begin
         work_qual = qual_sat;
      end

      if (use_digit) begin
         if (is_digit) begin
            work_seen  = 1'b1;
            work_phase = PH_DIGITS;
            if (!big_ff) begin
               if (acc_over) begin
                  work_big = 1'b1;
               end else begin
                  work_num = num_acc[NUM_W-1:0];
               end
            end
         end else begin
            work_phase = PH_TAIL;
         end
      end

      // Hold unless a transfer; the last character restarts the name
      phase_in = phase_ff;
      neg_in   = neg_ff;
      qual_in  = qual_ff;
      num_in   = num_ff;
      big_in   = big_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (req_last) begin
            phase_in = PH_START;
            neg_in   = 1'b0;
            qual_in  = '0;
            num_in   = '0;
            big_in   = 1'b0;
            seen_in  = 1'b0;
         end else begin
            phase_in = work_phase;
            neg_in   = work_neg;
            qual_in  = work_qual;
            num_in   = work_num;
            big_in   = work_big;
            seen_in  = work_seen;
         end
      end

      info_in.is_negative = work_neg;
      info_in.quality     = work_qual;
      info_in.numeral     = work_num;
      info_in.too_big     = work_big;
      info_in.digits_seen = work_seen;

      if (accept && req_last) begin
         info_valid_in = 1'b1;
      end else if (info_ready) begin
         info_valid_in = 1'b0;
      end else begin
         info_valid_in = info_valid_ff;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         neg_ff        <= 1'b0;
         qual_ff       <= '0;
         num_ff        <= '0;
         big_ff        <= 1'b0;
         seen_ff       <= 1'b0;
         info_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         qual_ff       <= qual_in;
         num_ff        <= num_in;
         big_ff        <= big_in;
         seen_ff       <= seen_in;
         info_valid_ff <= info_valid_in;
      end
   end

   // Parsed name register
   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         info_ff <= info_in;
      end
   end

endmodule

[hdl/ivnp_calc.sv]
`timescale 1ns / 1ps

module ivnp_calc (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    info_valid,
   output logic                    info_ready,
   input  ivnp_pkg::name_info_type info,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ivnp_pkg::result_type    rsp
);
   import ivnp_pkg::*;

   // Exact divide by seven through a reciprocal multiply
   localparam int DIV_K = NUM_W + 3;
   localparam int DIV_M = ((1 << DIV_K) + 6) / 7;
   localparam int PROD_W = 2 * NUM_W + 1;
   localparam int CALC_W = (NUM_W + 3 > 10) ? NUM_W + 3 : 10;

   localparam logic signed [CALC_W-1:0] WHOLE_MAX = CALC_W'(255);
   localparam logic signed [CALC_W-1:0] WHOLE_MIN = CALC_W'(-256);
   localparam logic signed [CALC_W-1:0] HALF_MAX  = CALC_W'(127);
   localparam logic signed [CALC_W-1:0] HALF_MIN  = CALC_W'(-128);

   // Major scale steps from the unison, per degree
   function automatic logic [2:0] scale_whole(input logic [2:0] deg);
      case (deg)
         3'd0:    scale_whole = 3'd0;
         3'd1:    scale_whole = 3'd1;
         3'd2:    scale_whole = 3'd2;
         3'd3:    scale_whole = 3'd2;
         3'd4:    scale_whole = 3'd3;
         3'd5:    scale_whole = 3'd4;
         3'd6:    scale_whole = 3'd5;
         default: scale_whole = 3'd0;
      endcase
   endfunction

   function automatic logic scale_half(input logic [2:0] deg);
      case (deg)
         3'd3, 3'd4, 3'd5, 3'd6: scale_half = 1'b1;
         default:                scale_half = 1'b0;
      endcase
   endfunction

   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff, rsp_in;
   logic                     load;

   logic [NUM_W-1:0]         degree_idx;
   logic [PROD_W-1:0]        prod;
   logic [NUM_W-1:0]         octave;
   logic [NUM_W+2:0]         rem_full;
   logic [2:0]               step;
   logic                     perfect;
   logic [CALC_W-1:0]        oct_ext;
   logic signed [CALC_W-1:0] q_ext, whole_raw, half_raw, whole_sgn, half_sgn;
   logic signed [CALC_W-1:0] whole_clip, half_clip;

   assign info_ready = !rsp_valid_ff || rsp_ready;
   assign load       = info_valid && info_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

   // Degree and octave of the numeral
   assign degree_idx = info.numeral - NUM_W'(1);
   assign prod       = PROD_W'(degree_idx) * PROD_W'(DIV_M);
   assign octave     = NUM_W'(prod >> DIV_K);
   assign rem_full   = (NUM_W + 3)'(degree_idx)
                       - (((NUM_W + 3)'(octave) << 3) - (NUM_W + 3)'(octave));
   assign step       = rem_full[2:0];
   assign perfect    = step inside {3'd0, 3'd3, 3'd4};

   // Step counts, with the perfect-class quality adjustment
   always_comb begin
      q_ext = {{(CALC_W - QUAL_W){info.quality[QUAL_W-1]}}, info.quality};
      if (info.quality < 0 && perfect) begin
         q_ext = q_ext + CALC_W'(1);
      end
      oct_ext   = CALC_W'(octave);
      whole_raw = $signed(CALC_W'(scale_whole(step)) + (oct_ext << 2) + oct_ext) + q_ext;
      half_raw  = $signed(CALC_W'(scale_half(step)) + (oct_ext << 1)) - q_ext;
      whole_sgn = info.is_negative ? -whole_raw : whole_raw;
      half_sgn  = info.is_negative ? -half_raw : half_raw;

      if (whole_sgn > WHOLE_MAX) begin
         whole_clip = WHOLE_MAX;
      end else if (whole_sgn < WHOLE_MIN) begin
         whole_clip = WHOLE_MIN;
      end else begin
         whole_clip = whole_sgn;
      end
      if (half_sgn > HALF_MAX) begin
         half_clip = HALF_MAX;
      end else if (half_sgn < HALF_MIN) begin
         half_clip = HALF_MIN;
      end else begin
         half_clip = half_sgn;
      end

      // Errors report zero counts
      if (!info.digits_seen) begin
         rsp_in.error_code  = ERR_NO_DIGITS;
         rsp_in.whole_steps = '0;
         rsp_in.half_steps  = '0;
      end else if (info.too_big || info.numeral == '0) begin
         rsp_in.error_code  = ERR_RANGE;
         rsp_in.whole_steps = '0;
         rsp_in.half_steps  = '0;
      end else begin
         rsp_in.error_code  = ERR_OK;
         rsp_in.whole_steps = whole_clip[WHOLE_W-1:0];
         rsp_in.half_steps  = half_clip[HALF_W-1:0];
      end
   end

   // Result valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[hdl/interval_name_parser_top.sv]
`timescale 1ns / 1ps

// Interval name parser.
// The req channel carries the name one ASCII character per transfer, with
// req_tlast on the final character. Every character updates the parse state
// (sign, quality, numeral); the last one produces one rsp transfer carrying
// the whole and half step counts and an error code (0 ok, 1 no digits,
// 2 numeral zero or above the limit, counts then zero).
// Throughput: one character per cycle while req_tready is high. After the
// transfer of the last character the result passes through the parsed-name
// register, then the result register.
// Reset clears the parse state and empties both pipeline registers; the first
// character after reset starts a new name.
// When the receiver stalls, the result register holds its item and the
// parsed-name register takes one more finished name; while that name waits
// on the result register, req_tready stays low for every character.
module interval_name_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [8:0] whole_steps, [16:9] half_steps,
                                    // [18:17] error_code, [23:19] zero
);
   import ivnp_pkg::*;

   logic          info_valid, info_ready;
   name_info_type info;
   result_type    rsp;

   ivnp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_char   (req_tdata),
      .req_last   (req_tlast),
      .info_valid (info_valid),
      .info_ready (info_ready),
      .info       (info)
   );

   ivnp_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .info_valid (info_valid),
      .info_ready (info_ready),
      .info       (info),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp};

   // Error code is always one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.error_code == ERR_OK || rsp.error_code == ERR_NO_DIGITS
                      || rsp.error_code == ERR_RANGE))
      else $error("undefined error code on result");

   // An error result carries zero counts
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.error_code != ERR_OK) |-> (rsp.whole_steps == '0
                                                    && rsp.half_steps == '0))
      else $error("error result with nonzero counts");

   // A transfer of the last character always yields a parsed name
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> info_valid)
      else $error("last character lost");

   // A parsed name waiting on the result register is not dropped
   assert property (@(posedge clock) disable iff (reset)
      (info_valid && !info_ready) |=> (info_valid && $stable(info)))
      else $error("parsed name dropped while stalled");

endmodule
